### rtl/hrsp_pkg.sv
// ============================================================================
// hrsp_pkg
// Shared types and constants for the hex record stream parser.
// ============================================================================
package hrsp_pkg;

    localparam int unsigned ADDR_WIDTH = 16;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_A_LO    = 8'h61;
    localparam logic [7:0] CHAR_F_LO    = 8'h66;
    localparam logic [7:0] CHAR_A_UP    = 8'h41;
    localparam logic [7:0] CHAR_F_UP    = 8'h46;
    localparam logic [3:0] NIBBLE_TEN   = 4'd10;

    localparam logic [2:0] KIND_WRITE      = 3'd0;
    localparam logic [2:0] KIND_END        = 3'd1;
    localparam logic [2:0] KIND_NO_COLON   = 3'd2;
    localparam logic [2:0] KIND_BAD_HEX    = 3'd3;
    localparam logic [2:0] KIND_NO_NEWLINE = 3'd4;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } parse_res_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
    } hex_digit_t;

endpackage

### rtl/hrsp_hex_decode.sv
// ============================================================================
// hrsp_hex_decode
// Classifies one character as a hex digit and returns its nibble value.
// ============================================================================
module hrsp_hex_decode (
    input  hrsp_pkg::in_item_t   item,
    output hrsp_pkg::hex_digit_t digit
);
    import hrsp_pkg::*;

    logic [7:0] lower_off;
    logic [7:0] upper_off;

    assign lower_off = item.character - CHAR_A_LO;
    assign upper_off = item.character - CHAR_A_UP;

    always_comb begin
        digit.is_hex = 1'b0;
        digit.nibble = 4'd0;
        if (!item.end_of_input) begin
            if (item.character >= CHAR_0 && item.character <= CHAR_9) begin
                digit.is_hex = 1'b1;
                digit.nibble = item.character[3:0];
            end else if (item.character >= CHAR_A_LO && item.character <= CHAR_F_LO) begin
                digit.is_hex = 1'b1;
                digit.nibble = lower_off[3:0] + NIBBLE_TEN;
            end else if (item.character >= CHAR_A_UP && item.character <= CHAR_F_UP) begin
                digit.is_hex = 1'b1;
                digit.nibble = upper_off[3:0] + NIBBLE_TEN;
            end
        end
    end

endmodule

### rtl/hrsp_parse_core.sv
// ============================================================================
// hrsp_parse_core
// Record phase state machine: consumes one registered character per advance
// and produces at most one result for the output register.
// ============================================================================
module hrsp_parse_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  hrsp_pkg::in_item_t   item,
    output hrsp_pkg::parse_res_t res
);
    import hrsp_pkg::*;

    typedef enum logic [15:0] {
        PH_COLON   = 16'h0001,
        PH_CNT_HI  = 16'h0002,
        PH_CNT_LO  = 16'h0004,
        PH_ADDR0   = 16'h0008,
        PH_ADDR1   = 16'h0010,
        PH_ADDR2   = 16'h0020,
        PH_ADDR3   = 16'h0040,
        PH_TYPE_HI = 16'h0080,
        PH_TYPE_LO = 16'h0100,
        PH_DATA_HI = 16'h0200,
        PH_DATA_LO = 16'h0400,
        PH_SUM_HI  = 16'h0800,
        PH_SUM_LO  = 16'h1000,
        PH_NEWLINE = 16'h2000,
        PH_DONE    = 16'h4000,
        PH_HALT    = 16'h8000
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [3:0]              pending_reg, pending_next;
    logic [7:0]              bytes_left_reg, bytes_left_next;
    logic [ADDR_WIDTH-1:0]   pointer_reg, pointer_next;
    logic [ADDR_WIDTH-1:0]   pointer_shift;
    logic [31:0]             pointer_wide;
    hex_digit_t              digit;

    hrsp_hex_decode u_hex_decode (
        .item  (item),
        .digit (digit)
    );

    assign pointer_shift = {pointer_reg[ADDR_WIDTH-5:0], digit.nibble};
    assign pointer_wide  = 32'(pointer_reg);

    always_comb begin
        phase_next      = phase_reg;
        pending_next    = pending_reg;
        bytes_left_next = bytes_left_reg;
        pointer_next    = pointer_reg;
        res             = '0;
        if (advance) begin
            unique case (phase_reg)
                PH_COLON: begin
                    if (item.end_of_input || item.character != CHAR_COLON) begin
                        phase_next           = PH_HALT;
                        res.valid            = 1'b1;
                        res.item.result_kind = KIND_NO_COLON;
                    end else begin
                        phase_next = PH_CNT_HI;
                    end
                end
                PH_NEWLINE: begin
                    if (item.end_of_input || item.character != CHAR_NEWLINE) begin
                        phase_next           = PH_HALT;
                        res.valid            = 1'b1;
                        res.item.result_kind = KIND_NO_NEWLINE;
                    end else begin
                        phase_next = PH_COLON;
                    end
                end
                PH_DONE, PH_HALT: begin
                    phase_next = phase_reg;
                end
                default: begin
                    if (!digit.is_hex) begin
                        phase_next           = PH_HALT;
                        res.valid            = 1'b1;
                        res.item.result_kind = KIND_BAD_HEX;
                    end else begin
                        unique case (phase_reg)
                            PH_CNT_HI: begin
                                pending_next = digit.nibble;
                                phase_next   = PH_CNT_LO;
                            end
                            PH_CNT_LO: begin
                                bytes_left_next = {pending_reg, digit.nibble};
                                phase_next      = PH_ADDR0;
                            end
                            PH_ADDR0: begin
                                pointer_next = ADDR_WIDTH'(digit.nibble);
                                phase_next   = PH_ADDR1;
                            end
                            PH_ADDR1: begin
                                pointer_next = pointer_shift;
                                phase_next   = PH_ADDR2;
                            end
                            PH_ADDR2: begin
                                pointer_next = pointer_shift;
                                phase_next   = PH_ADDR3;
                            end
                            PH_ADDR3: begin
                                pointer_next = pointer_shift;
                                if (bytes_left_reg == 8'd0) begin
                                    phase_next           = PH_DONE;
                                    res.valid            = 1'b1;
                                    res.item.result_kind = KIND_END;
                                end else begin
                                    phase_next = PH_TYPE_HI;
                                end
                            end
                            PH_TYPE_HI: phase_next = PH_TYPE_LO;
                            PH_TYPE_LO: phase_next = PH_DATA_HI;
                            PH_DATA_HI: begin
                                pending_next = digit.nibble;
                                phase_next   = PH_DATA_LO;
                            end
                            PH_DATA_LO: begin
                                res.valid              = 1'b1;
                                res.item.result_kind   = KIND_WRITE;
                                res.item.write_address = pointer_wide[15:0];
                                res.item.write_data    = {pending_reg, digit.nibble};
                                pointer_next           = pointer_reg + 1'b1;
                                bytes_left_next        = bytes_left_reg - 8'd1;
                                phase_next = (bytes_left_reg == 8'd1) ? PH_SUM_HI : PH_DATA_HI;
                            end
                            PH_SUM_HI: phase_next = PH_SUM_LO;
                            PH_SUM_LO: phase_next = PH_NEWLINE;
                            default:   phase_next = PH_HALT;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_COLON;
            pending_reg    <= 4'd0;
            bytes_left_reg <= 8'd0;
            pointer_reg    <= '0;
        end else begin
            phase_reg      <= phase_next;
            pending_reg    <= pending_next;
            bytes_left_reg <= bytes_left_next;
            pointer_reg    <= pointer_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> advance)
        else $error("Result produced without an advancing item.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE || phase_reg == PH_HALT) |-> !res.valid)
        else $error("Result produced after end record or error.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && (res.item.result_kind == KIND_NO_COLON ||
                      res.item.result_kind == KIND_BAD_HEX ||
                      res.item.result_kind == KIND_NO_NEWLINE) |=> phase_reg == PH_HALT)
        else $error("Parser did not halt after an error result.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_next == PH_DONE && phase_reg != PH_DONE) |->
            (res.valid && res.item.result_kind == KIND_END))
        else $error("Parser finished without an end result.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA_HI || phase_reg == PH_DATA_LO) |-> bytes_left_reg != 8'd0)
        else $error("Data phase entered with no bytes left.");

endmodule

### rtl/hex_record_stream_parser.sv
// ============================================================================
// hex_record_stream_parser
// Parses a hex record character stream into memory write items.
// ============================================================================
// Characters enter on the s_ channel, one item per character, with
// end_of_input marking the end of the stream. Results leave on the m_
// channel: a data write with its address and byte, an end record marker, or
// one of three error kinds. Characters that complete nothing give no result.
// An accepted character sits in an input register; when the output register
// is free or being taken, the phase logic consumes it and loads any result
// into the output register, from which the receiver takes it.
// Throughput is one character per cycle while the output register is free or
// being taken; the phase update of a single character is the only work
// between the two registers.
// When the receiver holds m_ready low with a result waiting, the input
// register still takes one more character, then s_ready drops until the
// result is taken. After an error or an end record the block keeps taking
// characters but gives no result until aresetn is asserted.
// Reset clears the parse phase, both registers' valid bits and the counters.
// ============================================================================
module hex_record_stream_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrsp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hrsp_pkg::out_item_t m_item
);
    import hrsp_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       advance;
    parse_res_t res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    hrsp_parse_core u_parse_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_item_reg <= res.item;
        end
    end

endmodule
